[rtl/core/lrs_pkg.sv]
package lrs_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned LineW = 64;
  localparam int unsigned EntryCountW = 7;

  typedef enum logic [1:0] {
    OpClear  = 2'd0,
    OpLoad   = 2'd1,
    OpRewind = 2'd2,
    OpTest   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusMerged  = 2'd1,
    StatusFull    = 2'd2,
    StatusInvalid = 2'd3
  } status_e;

  typedef struct packed {
    logic             kind;
    logic [LineW-1:0] first;
    logic [LineW-1:0] last;
  } entry_t;

endpackage

[rtl/core/lrs_ram.sv]
module lrs_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/line_range_selector_unit.sv]
// Each transaction is registered in s0, its result in the output register. One
// transaction per cycle unless stalled; the table RAM is read one entry ahead
// of the match pointer, and the last and first entries sit in registers.
// Reset: rst_ni is asynchronous, active low, and empties the table and rewinds
// the match pointer; no clearing pass is needed, stored entries stay undefined.
module line_range_selector_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         opcode_i,
  input  logic                               is_range_i,
  input  logic [lrs_pkg::LineW-1:0]          range_start_i,
  input  logic [lrs_pkg::LineW-1:0]          range_end_i,
  input  logic [lrs_pkg::LineW-1:0]          line_number_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               selected_o,
  output logic [1:0]                         status_o,
  output logic [lrs_pkg::EntryCountW-1:0]    entry_count_o
);

  logic                      s0_valid_q;
  logic [1:0]                s0_op_q;
  logic                      s0_range_q;
  logic [lrs_pkg::LineW-1:0] s0_start_q;
  logic [lrs_pkg::LineW-1:0] s0_end_q;
  logic [lrs_pkg::LineW-1:0] s0_line_q;

  logic                      out_valid_q;
  logic                      sel_q;
  lrs_pkg::status_e          status_q;
  logic [lrs_pkg::CntW-1:0]  count_out_q;

  logic [lrs_pkg::CntW-1:0]  count_q, count_d;
  logic [lrs_pkg::CntW-1:0]  mp_q, mp_d;
  lrs_pkg::entry_t           last_q, last_d;
  lrs_pkg::entry_t           head_q, head_d;
  lrs_pkg::entry_t           cur_q, cur_d;
  logic                      byp_q;
  lrs_pkg::entry_t           byp_data_q;

  logic                      s1_ready;
  logic                      s0_fire;
  lrs_pkg::opcode_e          op;
  lrs_pkg::entry_t           nxt;
  lrs_pkg::entry_t           ram_rdata;
  logic                      we;
  logic [lrs_pkg::CntW-1:0]  waddr;
  lrs_pkg::entry_t           wdata;
  logic [lrs_pkg::CntW-1:0]  raddr;
  logic                      sel_d;
  lrs_pkg::status_e          status_d;

  logic [lrs_pkg::LineW-1:0] ne;
  logic                      invalid;
  logic                      merge_ok;
  logic [lrs_pkg::LineW-1:0] max_end;
  logic                      cur_valid;

  assign s1_ready   = !out_valid_q || out_ready_i;
  assign s0_fire    = s0_valid_q && s1_ready;
  assign in_ready_o = !s0_valid_q || s1_ready;
  assign op         = lrs_pkg::opcode_e'(s0_op_q);
  assign nxt        = byp_q ? byp_data_q : ram_rdata;

  assign ne        = s0_range_q ? s0_end_q : s0_start_q;
  assign invalid   = (s0_start_q == '0) || (s0_start_q > ne);
  assign max_end   = (last_q.last > ne) ? last_q.last : ne;
  assign merge_ok  = (count_q != '0) &&
                     ((last_q.first == s0_start_q) ||
                      (last_q.kind && s0_range_q &&
                       ((last_q.last >= s0_start_q) ||
                        (last_q.last + 1'b1 == s0_start_q))) ||
                      (last_q.kind && !s0_range_q && (last_q.last >= s0_start_q)));
  assign cur_valid = mp_q < count_q;

  always_comb begin
    count_d  = count_q;
    mp_d     = mp_q;
    last_d   = last_q;
    we       = 1'b0;
    waddr    = count_q;
    wdata    = last_q;
    sel_d    = 1'b0;
    status_d = lrs_pkg::StatusOk;
    if (s0_fire) begin
      case (op)
        lrs_pkg::OpClear: begin
          count_d = '0;
          mp_d    = '0;
        end
        lrs_pkg::OpLoad: begin
          if (invalid) begin
            status_d = lrs_pkg::StatusInvalid;
          end else if (merge_ok) begin
            status_d   = lrs_pkg::StatusMerged;
            we         = 1'b1;
            waddr      = count_q - 1'b1;
            wdata.kind = last_q.kind | s0_range_q;
            wdata.first = last_q.first;
            wdata.last = s0_range_q ? (last_q.kind ? max_end : ne) : last_q.last;
            last_d     = wdata;
          end else if (count_q == lrs_pkg::CntW'(lrs_pkg::TableDepth)) begin
            status_d = lrs_pkg::StatusFull;
          end else begin
            we          = 1'b1;
            waddr       = count_q;
            wdata.kind  = s0_range_q;
            wdata.first = s0_start_q;
            wdata.last  = ne;
            last_d      = wdata;
            count_d     = count_q + 1'b1;
          end
        end
        lrs_pkg::OpRewind: begin
          mp_d = '0;
        end
        lrs_pkg::OpTest: begin
          if (cur_valid) begin
            if (!cur_q.kind) begin
              if (cur_q.first == s0_line_q) begin
                sel_d = 1'b1;
                mp_d  = mp_q + 1'b1;
              end
            end else if (cur_q.first <= s0_line_q) begin
              sel_d = 1'b1;
              if (cur_q.last == s0_line_q) begin
                mp_d = mp_q + 1'b1;
              end
            end
          end
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_comb begin
    head_d = head_q;
    if (we && (waddr == '0)) begin
      head_d = wdata;
    end
    cur_d = cur_q;
    if (we && (waddr == mp_q)) begin
      cur_d = wdata;
    end else if (s0_fire && (op == lrs_pkg::OpRewind)) begin
      cur_d = head_q;
    end else if (mp_d != mp_q) begin
      cur_d = nxt;
    end
  end

  assign raddr = mp_d + 1'b1;

  lrs_ram #(
    .DEPTH (lrs_pkg::TableDepth),
    .WIDTH ($bits(lrs_pkg::entry_t))
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr[lrs_pkg::IdxW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr[lrs_pkg::IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      mp_q        <= '0;
      byp_q       <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s0_valid_q <= in_valid_i;
      end
      if (s1_ready) begin
        out_valid_q <= s0_valid_q;
      end
      count_q <= count_d;
      mp_q    <= mp_d;
      byp_q   <= we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s0_op_q    <= opcode_i;
      s0_range_q <= is_range_i;
      s0_start_q <= range_start_i;
      s0_end_q   <= range_end_i;
      s0_line_q  <= line_number_i;
    end
    if (s0_fire) begin
      sel_q       <= sel_d;
      status_q    <= status_d;
      count_out_q <= count_d;
    end
    last_q     <= last_d;
    head_q     <= head_d;
    cur_q      <= cur_d;
    byp_data_q <= wdata;
  end

  assign out_valid_o   = out_valid_q;
  assign selected_o    = sel_q;
  assign status_o      = status_q;
  assign entry_count_o = lrs_pkg::EntryCountW'(count_out_q);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lrs_pkg::CntW'(lrs_pkg::TableDepth))
    else $error("stored count exceeds table depth");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mp_q <= count_q)
    else $error("match pointer beyond stored count");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_fire && (op == lrs_pkg::OpClear)) |=> (count_q == '0) && (mp_q == '0))
    else $error("clear transaction did not empty the table");

  a_sel_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_fire && sel_d) |-> (mp_q < count_q) && (op == lrs_pkg::OpTest))
    else $error("selection without a stored entry under the pointer");
`endif

endmodule

[dv/line_range_selector_unit_test.sv]
`timescale 1ns / 100ps

module line_range_selector_unit_test;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned LineW = lrs_pkg::LineW;
  localparam int unsigned EntryCountW = lrs_pkg::EntryCountW;
  localparam int unsigned TableDepth = lrs_pkg::TableDepth;

  typedef struct packed {
    logic             sel;
    lrs_pkg::status_e status;
    logic [EntryCountW-1:0] count;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] opcode_i = lrs_pkg::OpClear;
  logic is_range_i = 1'b0;
  logic [LineW-1:0] range_start_i = '0;
  logic [LineW-1:0] range_end_i = '0;
  logic [LineW-1:0] line_number_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic selected_o;
  logic [1:0] status_o;
  logic [EntryCountW-1:0] entry_count_o;

  lrs_pkg::entry_t cond_tbl [TableDepth];
  int unsigned held_cnt = 0;
  int unsigned match_ptr = 0;
  verdict_t verdict_q [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit no_idle = 1'b0;

  line_range_selector_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .is_range_i   (is_range_i),
    .range_start_i(range_start_i),
    .range_end_i  (range_end_i),
    .line_number_i(line_number_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .selected_o   (selected_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [LineW-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // A new condition folds into the last stored entry when it shares its start,
  // overlaps or touches a stored range, or is a single inside a stored range.
  function automatic bit fold_into_last(logic nr, logic [LineW-1:0] ns,
                                        logic [LineW-1:0] ne);
    lrs_pkg::entry_t e;
    e = cond_tbl[held_cnt - 1];
    if (e.first == ns) begin
      if (e.kind && nr) begin
        e.last = (ne > e.last) ? ne : e.last;
      end else if (!e.kind && nr) begin
        e.kind = 1'b1;
        e.last = ne;
      end
      cond_tbl[held_cnt - 1] = e;
      return 1'b1;
    end
    if (e.kind && nr && (e.last >= ns || e.last + 64'd1 == ns)) begin
      e.last = (ne > e.last) ? ne : e.last;
      cond_tbl[held_cnt - 1] = e;
      return 1'b1;
    end
    return e.kind && !nr && e.last >= ns;
  endfunction

  function automatic verdict_t predict_verdict(lrs_pkg::opcode_e op, logic nr,
                                               logic [LineW-1:0] ns,
                                               logic [LineW-1:0] ne_in,
                                               logic [LineW-1:0] line);
    verdict_t v;
    lrs_pkg::entry_t cur;
    logic [LineW-1:0] ne;
    v = '0;
    ne = nr ? ne_in : ns;
    case (op)
      lrs_pkg::OpClear: begin
        held_cnt = 0;
        match_ptr = 0;
      end
      lrs_pkg::OpLoad: begin
        if (ns == '0 || ns > ne) begin
          v.status = lrs_pkg::StatusInvalid;
        end else if (held_cnt > 0 && fold_into_last(nr, ns, ne)) begin
          v.status = lrs_pkg::StatusMerged;
        end else if (held_cnt >= TableDepth) begin
          v.status = lrs_pkg::StatusFull;
        end else begin
          cond_tbl[held_cnt] = '{kind: nr, first: ns, last: ne};
          held_cnt++;
          v.status = lrs_pkg::StatusOk;
        end
      end
      lrs_pkg::OpRewind: begin
        match_ptr = 0;
      end
      default: begin
        if (match_ptr < held_cnt) begin
          cur = cond_tbl[match_ptr];
          if (!cur.kind) begin
            if (cur.first == line) begin
              match_ptr++;
              v.sel = 1'b1;
            end
          end else if (cur.first <= line) begin
            if (cur.last == line) begin
              match_ptr++;
            end
            v.sel = 1'b1;
          end
        end
      end
    endcase
    v.count = EntryCountW'(held_cnt);
    return v;
  endfunction

  // Entered and left just after a falling edge; valid stays high into the
  // next transaction when no idle cycles are drawn.
  task automatic send_item(lrs_pkg::opcode_e op, logic nr, logic [LineW-1:0] first,
                           logic [LineW-1:0] last, logic [LineW-1:0] line);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    is_range_i <= nr;
    range_start_i <= first;
    range_end_i <= last;
    line_number_i <= line;
    verdict_q.push_back(predict_verdict(op, nr, first, last, line));
    items_sent++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_empty_table();
    send_item(lrs_pkg::OpTest, 1'b0, '0, '0, 64'd1);
    send_item(lrs_pkg::OpRewind, 1'b1, '1, '1, '1);
    send_item(lrs_pkg::OpClear, 1'b0, '1, '0, '1);
  endtask

  task automatic test_invalid_loads();
    send_item(lrs_pkg::OpLoad, 1'b0, '0, 64'd9, '0);
    send_item(lrs_pkg::OpLoad, 1'b1, '0, '1, '0);
    send_item(lrs_pkg::OpLoad, 1'b1, '1, '1 - 64'd1, '0);
    send_item(lrs_pkg::OpLoad, 1'b0, 64'd5, '0, '0);
  endtask

  task automatic test_merge_rules();
    send_item(lrs_pkg::OpClear, 1'b0, '0, '0, '0);
    send_item(lrs_pkg::OpLoad, 1'b1, 64'd10, 64'd20, '0);
    send_item(lrs_pkg::OpLoad, 1'b1, 64'd10, 64'd15, '0);
    send_item(lrs_pkg::OpLoad, 1'b1, 64'd15, 64'd30, '0);
    send_item(lrs_pkg::OpLoad, 1'b1, 64'd31, 64'd40, '0);
    send_item(lrs_pkg::OpLoad, 1'b0, 64'd35, 64'd35, '0);
    send_item(lrs_pkg::OpLoad, 1'b0, 64'd50, 64'd50, '0);
    send_item(lrs_pkg::OpLoad, 1'b1, 64'd50, 64'd60, '0);
    send_item(lrs_pkg::OpLoad, 1'b0, 64'd61, 64'd3, '0);
    send_item(lrs_pkg::OpLoad, 1'b0, 64'd61, 64'd61, '0);
    send_item(lrs_pkg::OpLoad, 1'b1, 64'd100, '1, '0);
    send_item(lrs_pkg::OpLoad, 1'b1, '1, '1, '0);
  endtask

  task automatic test_range_matching();
    send_item(lrs_pkg::OpRewind, 1'b0, '0, '0, '0);
    send_item(lrs_pkg::OpTest, 1'b0, '0, '0, 64'd9);
    send_item(lrs_pkg::OpTest, 1'b1, '0, '0, 64'd10);
    send_item(lrs_pkg::OpTest, 1'b0, '0, '0, 64'd40);
    send_item(lrs_pkg::OpTest, 1'b0, '0, '0, 64'd55);
    send_item(lrs_pkg::OpTest, 1'b0, '0, '0, 64'd61);
  endtask

  task automatic load_sorted_conditions(int unsigned n, logic [LineW-1:0] origin,
                                        bit spread);
    logic [LineW-1:0] start;
    logic [LineW-1:0] stop;
    bit nr;
    start = origin;
    for (int unsigned k = 0; k < n; k++) begin
      nr = 1'($urandom_range(0, 1));
      if (spread) begin
        start += LineW'($urandom_range(30, 60));
      end else begin
        case ($urandom_range(0, 3))
          0: start += LineW'(0);
          1: start += LineW'(1);
          default: start += LineW'($urandom_range(2, 12));
        endcase
      end
      stop = start + LineW'($urandom_range(0, 20));
      if (stop < start) begin
        stop = '1;
      end
      case (spread ? 2 : $urandom_range(0, 15))
        0: send_item(lrs_pkg::OpLoad, nr, '0, stop, random_word());
        1: send_item(lrs_pkg::OpLoad, 1'b1, start, start - 64'd1, random_word());
        default: send_item(lrs_pkg::OpLoad, nr, start, nr ? stop : random_word(),
                           random_word());
      endcase
    end
  endtask

  task automatic scan_lines(logic [LineW-1:0] from, int unsigned n);
    logic [LineW-1:0] line;
    line = from;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: line -= LineW'($urandom_range(1, 4));
        1: line += LineW'($urandom_range(5, 40));
        default: line += LineW'($urandom_range(0, 2));
      endcase
      send_item(lrs_pkg::OpTest, 1'($urandom_range(0, 1)), random_word(), random_word(),
                line);
    end
  endtask

  task automatic test_random_sessions();
    logic [LineW-1:0] origin;
    bit spread;
    while (items_sent < RandomItems) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(3, 10)) begin
          send_item(lrs_pkg::opcode_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                    random_word(), random_word(), random_word());
        end
      end else begin
        spread = ($urandom_range(0, 5) == 0);
        case ($urandom_range(0, 2))
          0: origin = LineW'($urandom_range(1, 50));
          1: origin = random_word() | 64'h8000_0000_0000_0000;
          default: origin = random_word();
        endcase
        if (spread) begin
          origin = LineW'($urandom_range(1, 1000));
        end
        if ($urandom_range(0, 7) != 0) begin
          send_item(lrs_pkg::OpClear, 1'($urandom_range(0, 1)), random_word(),
                    random_word(), random_word());
        end
        load_sorted_conditions(spread ? $urandom_range(64, 72) : $urandom_range(1, 12),
                               origin, spread);
        if ($urandom_range(0, 3) != 0) begin
          send_item(lrs_pkg::OpRewind, 1'($urandom_range(0, 1)), random_word(),
                    random_word(), random_word());
        end
        scan_lines(origin - LineW'($urandom_range(0, 3)), $urandom_range(10, 40));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin : out_ready_driver
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    verdict_t want;
    verdict_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {selected_o, status_o, entry_count_o};
      if (verdict_q.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("Unexpected transaction: selected=%0b status=%0d count=%0d",
                   selected_o, status_o, entry_count_o);
        end
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10) begin
            $display("Mismatch: expected selected=%0b status=%0d count=%0d, got %0b %0d %0d",
                     want.sel, want.status, want.count, selected_o, status_o, entry_count_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("line_range_selector_unit regression: fail");
    $finish;
  end

  initial begin : main_sequence
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_table();
    test_invalid_loads();
    test_merge_rules();
    test_range_matching();
    test_random_sessions();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("line_range_selector_unit regression: pass");
    end else begin
      $display("line_range_selector_unit regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/lrs_pkg.sv
rtl/core/lrs_ram.sv
rtl/core/line_range_selector_unit.sv
dv/line_range_selector_unit_test.sv
